// ----- src/lsr_pkg.sv -----
// shared constants, types and the interpolation function of the looped sample resampler
`default_nettype none

package lsr_pkg;

    // store geometry
    localparam int MAX_FRAMES = 65536;
    localparam int FRAME_AW   = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = FRAME_AW + 1;

    // phase layout: integer frame index over a 32-bit fraction
    localparam int PFRAC_W    = 32;
    localparam int PHASE_W    = FRAME_AW + PFRAC_W;
    localparam int FRAC_SHIFT = 20;
    localparam int FRAC_W     = 12;

    // beat fields
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 8;
    localparam int OUT_W    = 12;
    localparam int FRAME_W  = 2 * SAMPLE_W;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef logic                         t_op;
    typedef logic        [ADDR_W-1:0]     t_addr;
    typedef logic signed [SAMPLE_W-1:0]   t_sample;
    typedef logic signed [OUT_W-1:0]      t_out;
    typedef logic        [FRAC_W-1:0]     t_weight;
    typedef logic        [FRAME_AW-1:0]   t_frame_idx;
    typedef logic        [FRAME_W-1:0]    t_frame;
    typedef logic        [COUNT_W-1:0]    t_count;
    typedef logic        [PHASE_W-1:0]    t_phase;

    // operation codes
    localparam t_op OP_WRITE = 1'b0;
    localparam t_op OP_TICK  = 1'b1;

    // register indexes, taken from paddr bit 2
    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_PHASE_STEP  = 1'b1;

    // output limits
    localparam t_out OUT_MAX = 12'sd2047;
    localparam t_out OUT_MIN = -12'sd2048;

    // store access requests
    typedef struct packed {
        logic       en;
        t_frame_idx addr;
        t_frame     data;
    } t_wr_req;

    typedef struct packed {
        logic       en;
        t_frame_idx addr_a;
        t_frame_idx addr_b;
    } t_rd_req;

    // 16*a + floor((b - a) * w / 256), saturated to 12 bits
    function automatic t_out interp(t_sample a, t_sample b, t_weight w);
        logic signed [SAMPLE_W:0]   diff;
        logic signed [21:0]         prod;
        logic signed [13:0]         q;
        logic signed [14:0]         sum;
        t_out                       res;
        diff = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
        prod = diff * $signed({1'b0, w});
        q    = prod[21:8];
        sum  = {{3{a[SAMPLE_W-1]}}, a, 4'b0000} + {q[13], q};
        if (sum[14:11] == 4'b0000 || sum[14:11] == 4'b1111) begin
            res = sum[OUT_W-1:0];
        end else if (sum[14]) begin
            res = OUT_MIN;
        end else begin
            res = OUT_MAX;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/lsr_if.sv -----
// valid/ready stream interfaces for the command and the output frame channels
`default_nettype none

interface lsr_in_if import lsr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_op     operation;
    t_addr   write_address;
    t_sample left_sample;
    t_sample right_sample;

    modport source (
        output valid, operation, write_address, left_sample, right_sample,
        input  ready
    );
    modport sink (
        input  valid, operation, write_address, left_sample, right_sample,
        output ready
    );
endinterface

interface lsr_out_if import lsr_pkg::*; ();
    logic valid;
    logic ready;
    t_out left_out;
    t_out right_out;

    modport source (
        output valid, left_out, right_out,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/lsr_store.sv -----
// frame store: one write port, two read ports with registered read data
`default_nettype none

module lsr_store import lsr_pkg::*; (
    input  wire          i_clk,
    input  wire t_wr_req i_wr,
    input  wire t_rd_req i_rd,
    output t_frame       o_rd_data_a,
    output t_frame       o_rd_data_b
);

    t_frame r_mem [MAX_FRAMES];
    t_frame r_rd_data_a;
    t_frame r_rd_data_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // two read ports, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data_a <= r_mem[i_rd.addr_a];
            r_rd_data_b <= r_mem[i_rd.addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

`default_nettype wire

// ----- src/looped_sample_resampler.sv -----
// looped stereo sample player: top level with phase accumulator and interpolation
//
// usage:
//   i_in carries command beats. operation write stores one signed 8-bit stereo
//   frame at write_address and gives no output beat. operation tick gives one
//   12-bit stereo frame on o_out, interpolated between the frame at the phase
//   index and the next frame of the loop (zero when the loop is empty); the phase then advances by phase_step.
//   registers on the apb port: frame_count at 0x0 (writing it clears the phase),
//   phase_step at 0x4. write them only while no tick is in flight.
// path: a tick is read from the store into the read register, then interpolated
//   into the output register, which drives o_out.
// throughput: one beat per cycle while o_out takes beats; the phase add and the dual-port
//   store read of both neighbor frames all fit in the accept cycle.
// stall: while o_out waits, one more tick can be taken into the read stage;
//   after that i_in.ready drops until the output beat is taken.
// reset: synchronous, active low; clears the phase, the registers and all
//   valid flags. the store is not cleared: frames must be written before use.
`default_nettype none

module looped_sample_resampler import lsr_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    lsr_in_if.sink              i_in,
    lsr_out_if.source           o_out,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [APB_AW-1:0]   paddr,
    input  wire  [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // configuration and phase state
    t_count             r_frame_count;
    t_count             r_count_eff;
    logic [PFRAC_W-1:0] r_phase_step;
    t_phase             r_phase;
    t_phase             n_phase;

    // read stage and output register
    logic    r_s1_valid;
    logic    r_s1_empty;
    t_weight r_s1_w;
    logic    r_out_valid;
    t_out    r_out_left;
    t_out    r_out_right;

    logic       cfg_wr;
    logic       in_fire;
    logic       tick_fire;
    logic       wr_fire;
    logic       adv_out;
    logic       s1_move;
    logic       empty;
    t_frame_idx idx_raw;
    t_frame_idx idx;
    t_count     idx_inc;
    t_frame_idx nxt;
    logic [PHASE_W:0] phase_sum;
    t_count     sum_int;
    t_count     wrap_int;
    t_wr_req    wr_req;
    t_rd_req    rd_req;
    t_frame     frame_a;
    t_frame     frame_b;

    // apb access
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_COUNT: prdata = {{(APB_DW-COUNT_W){1'b0}}, r_frame_count};
            REG_PHASE_STEP:  prdata = r_phase_step;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_count_eff   <= '0;
            r_phase_step  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_COUNT: begin
                    r_frame_count <= pwdata[COUNT_W-1:0];
                    if (pwdata[COUNT_W-1:0] > COUNT_W'(MAX_FRAMES)) begin
                        r_count_eff <= COUNT_W'(MAX_FRAMES);
                    end else begin
                        r_count_eff <= pwdata[COUNT_W-1:0];
                    end
                end
                REG_PHASE_STEP: r_phase_step <= pwdata[PFRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign adv_out     = !r_out_valid | o_out.ready;
    assign s1_move     = r_s1_valid & adv_out;
    assign i_in.ready  = !r_s1_valid | adv_out;
    assign in_fire     = i_in.valid & i_in.ready;
    assign tick_fire   = in_fire & (i_in.operation == OP_TICK);
    assign wr_fire     = in_fire & (i_in.operation == OP_WRITE);
    assign empty       = (r_count_eff == '0);

    // frame indexes of the two neighbors, wrapping at the loop end
    assign idx_raw = r_phase[PHASE_W-1:PFRAC_W];
    assign idx     = ({1'b0, idx_raw} < r_count_eff) ? idx_raw : '0;
    assign idx_inc = {1'b0, idx} + COUNT_W'(1);
    assign nxt     = (idx_inc == r_count_eff) ? '0 : idx_inc[FRAME_AW-1:0];

    // phase advance with one wrap at the loop length
    assign phase_sum = {1'b0, r_phase} + {{(FRAME_AW+1){1'b0}}, r_phase_step};
    assign sum_int   = phase_sum[PHASE_W:PFRAC_W];
    assign wrap_int  = (sum_int >= r_count_eff) ? (sum_int - r_count_eff) : sum_int;

    always_comb begin
        n_phase = r_phase;
        if (cfg_wr && paddr[2] == REG_FRAME_COUNT) begin
            n_phase = '0;
        end else if (tick_fire && !empty) begin
            n_phase = {wrap_int[FRAME_AW-1:0], phase_sum[PFRAC_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // store access
    always_comb begin
        wr_req.en     = wr_fire & ({1'b0, i_in.write_address} < (ADDR_W+1)'(MAX_FRAMES));
        wr_req.addr   = i_in.write_address[FRAME_AW-1:0];
        wr_req.data   = {i_in.left_sample, i_in.right_sample};
        rd_req.en     = tick_fire;
        rd_req.addr_a = idx;
        rd_req.addr_b = nxt;
    end

    lsr_store u_store (
        .i_clk       (i_clk),
        .i_wr        (wr_req),
        .i_rd        (rd_req),
        .o_rd_data_a (frame_a),
        .o_rd_data_b (frame_b)
    );

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (tick_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_s1_empty <= empty;
            r_s1_w     <= r_phase[FRAC_SHIFT +: FRAC_W];
        end
    end

    // interpolation into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            if (r_s1_empty) begin
                r_out_left  <= '0;
                r_out_right <= '0;
            end else begin
                r_out_left  <= interp(frame_a[FRAME_W-1:SAMPLE_W],
                                      frame_b[FRAME_W-1:SAMPLE_W], r_s1_w);
                r_out_right <= interp(frame_a[SAMPLE_W-1:0],
                                      frame_b[SAMPLE_W-1:0], r_s1_w);
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;

`ifndef ASSERT_OFF
    // the phase index always stays inside the loop
    a_phase_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count_eff != '0) |-> ({1'b0, r_phase[PHASE_W-1:PFRAC_W]} < r_count_eff))
        else $error("phase index outside the loop");

    // writing frame_count restarts the loop
    a_count_clears_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[2] == REG_FRAME_COUNT) |=> (r_phase == '0))
        else $error("phase not cleared by frame_count write");

    // an accepted tick always occupies the read stage next cycle
    a_tick_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_fire |=> r_s1_valid)
        else $error("tick lost before the read stage");

    // a write beat never produces an output beat on its own
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_fire && !r_s1_valid) |=> !r_s1_valid)
        else $error("write beat entered the read stage");
`endif

endmodule

`default_nettype wire

// ----- sim/looped_sample_resampler_tb.sv -----
// self-checking testbench of the looped sample resampler: frame store, phase walk, backpressure

module looped_sample_resampler_tb;
    import lsr_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_GAP       = 60;
    localparam int LIMIT_CYCLES  = 2000000;

    typedef struct {
        t_out left;
        t_out right;
    } t_frame_pair;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lsr_in_if  in_bus ();
    lsr_out_if out_bus ();

    looped_sample_resampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the block state
    logic [COUNT_W-1:0] mirror_count = '0;
    logic [31:0]        mirror_step  = '0;
    logic [63:0]        mirror_phase = '0;
    t_frame             frame_mem   [MAX_FRAMES];
    bit                 frame_known [MAX_FRAMES];

    t_frame_pair pending_frames[$];

    int mismatches     = 0;
    int frames_checked = 0;
    int writes_sent    = 0;
    int ticks_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("looped_sample_resampler verification failed");
        $finish;
    end

    // output ready: random stalls, plus a long hold on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each output beat with the oldest predicted frame
    always @(posedge i_clk) begin
        t_frame_pair want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_frames.size() == 0) begin
                mismatches++;
                $display("%0t: output beat with nothing predicted, left %0d right %0d",
                         $time, out_bus.left_out, out_bus.right_out);
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (out_bus.left_out !== want.left) begin
                    mismatches++;
                    $display("%0t: left_out expected %0d actual %0d",
                             $time, want.left, out_bus.left_out);
                end
                if (out_bus.right_out !== want.right) begin
                    mismatches++;
                    $display("%0t: right_out expected %0d actual %0d",
                             $time, want.right, out_bus.right_out);
                end
            end
        end
    end

    // frames in the loop, count clipped to the store size
    function automatic int loop_frames();
        return (mirror_count > MAX_FRAMES) ? MAX_FRAMES : int'(mirror_count);
    endfunction

    // 16*a plus the floored weighted difference, clipped to 12 bits
    function automatic t_out blend_channel(int a, int b, int w);
        int acc;
        acc = 16 * a + (((b - a) * w) >>> 8);
        if (acc > 2047) acc = 2047;
        if (acc < -2048) acc = -2048;
        return t_out'(acc);
    endfunction

    // one tick: interpolate at the current phase, then step and wrap the phase
    task automatic predict_frame();
        t_frame_pair f;
        int          eff;
        int          idx;
        int          nxt;
        int          w;
        logic [63:0] wrap_span;
        eff = loop_frames();
        if (eff == 0) begin
            f.left  = '0;
            f.right = '0;
        end else begin
            idx = int'(mirror_phase[47:32]);
            if (idx >= eff) idx = 0;
            nxt = (idx + 1 == eff) ? 0 : idx + 1;
            w   = int'(mirror_phase[31:20]);
            f.left  = blend_channel($signed(frame_mem[idx][15:8]),
                                    $signed(frame_mem[nxt][15:8]), w);
            f.right = blend_channel($signed(frame_mem[idx][7:0]),
                                    $signed(frame_mem[nxt][7:0]), w);
            mirror_phase = mirror_phase + 64'(mirror_step);
            wrap_span = 64'(eff) << 32;
            if (mirror_phase >= wrap_span) mirror_phase = mirror_phase - wrap_span;
        end
        pending_frames.push_back(f);
    endtask

    // offer one command beat after a random gap and update the mirror on accept
    task automatic send_beat(t_op op, t_addr addr, t_sample l, t_sample r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.operation     <= op;
        in_bus.write_address <= addr;
        in_bus.left_sample   <= l;
        in_bus.right_sample  <= r;
        do @(posedge i_clk); while (!in_bus.ready);
        if (op == OP_WRITE) begin
            frame_mem[addr]   = {l, r};
            frame_known[addr] = 1'b1;
            writes_sent++;
        end else begin
            predict_frame();
            ticks_sent++;
        end
    endtask

    task automatic send_write(t_addr addr);
        send_beat(OP_WRITE, addr, t_sample'($urandom), t_sample'($urandom));
    endtask

    // make sure both frames the next tick reads hold data, then tick
    task automatic send_tick();
        int eff;
        int idx;
        int nxt;
        eff = loop_frames();
        if (eff != 0) begin
            idx = int'(mirror_phase[47:32]);
            if (idx >= eff) idx = 0;
            nxt = (idx + 1 == eff) ? 0 : idx + 1;
            if (!frame_known[idx]) send_write(t_addr'(idx));
            if (!frame_known[nxt]) send_write(t_addr'(nxt));
        end
        send_beat(OP_TICK, t_addr'($urandom), t_sample'($urandom), t_sample'($urandom));
    endtask

    // register write then read back, each with a setup and an access phase
    task automatic cfg_write(logic reg_sel, logic [31:0] value);
        logic [APB_DW-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == REG_FRAME_COUNT) begin
            mirror_count = value[COUNT_W-1:0];
            mirror_phase = '0;
            want = APB_DW'(value[COUNT_W-1:0]);
        end else begin
            mirror_step = value;
            want = value;
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            mismatches++;
            $display("%0t: readback of register %0d expected %h actual %h",
                     $time, reg_sel, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering beats, wait out every predicted frame and the pipeline
    task automatic drain_frames();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic retune(logic [COUNT_W-1:0] cnt, logic [31:0] stp);
        drain_frames();
        cfg_write(REG_FRAME_COUNT, APB_DW'(cnt));
        cfg_write(REG_PHASE_STEP, stp);
    endtask

    task automatic set_idle(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // empty loop gives silence, a write at the top address gives nothing
    task automatic test_empty_loop();
        set_idle(0, 0);
        retune('0, 32'h4000_0000);
        send_beat(OP_WRITE, 16'hffff, 8'sd127, -8'sd128);
        send_tick();
        send_tick();
    endtask

    // extreme samples at half, almost-one and zero steps with loop wrap
    task automatic test_interp_extremes();
        retune(2, 32'h8000_0000);
        send_beat(OP_WRITE, 16'h0000, 8'sd127, -8'sd128);
        send_beat(OP_WRITE, 16'h0001, -8'sd128, 8'sd127);
        repeat (4) send_tick();
        retune(2, 32'hffff_ffff);
        repeat (2) send_tick();
        retune(2, 32'h0000_0000);
        send_tick();
    endtask

    // single-frame loop reads the same frame as both neighbors
    task automatic test_single_frame();
        retune(1, 32'h9000_0000);
        repeat (2) send_tick();
    endtask

    // counts at and above the store size
    task automatic test_count_clip();
        retune(17'h1ffff, 32'h0010_0000);
        repeat (2) send_tick();
        retune(17'h10000, 32'hffff_ffff);
        send_tick();
    endtask

    // random phases over idle modes, loop sizes and steps
    task automatic test_random_traffic();
        int                 phase_no;
        int                 n;
        int                 pick;
        logic [COUNT_W-1:0] cnt;
        logic [31:0]        stp;
        for (phase_no = 0; phase_no < 12; phase_no++) begin
            case (phase_no % 4)
                0: set_idle(0, 0);
                1: set_idle(85, 0);
                2: set_idle(0, 85);
                default: set_idle(24, 24);
            endcase
            case ($urandom_range(7))
                0: cnt = 0;
                1: cnt = 1;
                2: cnt = 2;
                3: cnt = COUNT_W'($urandom_range(16, 3));
                4: cnt = COUNT_W'($urandom_range(400, 17));
                5: cnt = 17'h10000;
                6: cnt = 17'h1ffff;
                default: cnt = COUNT_W'($urandom_range(65535));
            endcase
            case ($urandom_range(4))
                0: stp = 32'h0000_0000;
                1: stp = 32'hffff_ffff;
                2: stp = $urandom;
                3: stp = $urandom_range(32'h00ff_ffff, 1);
                default: stp = $urandom_range(32'hc000_0000, 32'h0800_0000);
            endcase
            retune(cnt, stp);
            for (n = 0; n < 100; n++) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    send_tick();
                end else if (pick < 80 && loop_frames() != 0) begin
                    send_write(t_addr'($urandom_range(loop_frames() - 1)));
                end else begin
                    send_write(t_addr'($urandom));
                end
            end
        end
        drain_frames();
    endtask

    // long output hold while ticks keep coming, then a full pause and more ticks
    task automatic test_output_hold();
        set_idle(0, 0);
        retune(5, 32'h3000_0000);
        hold_req <= hold_req + 1;
        repeat (60) send_tick();
        drain_frames();
        set_idle(0, 24);
        repeat (20) send_tick();
        drain_frames();
    endtask

    // walk a short loop with an almost-one step past its end to see the wrap to frame 0
    task automatic test_loop_wrap_sweep();
        set_idle(0, 0);
        retune(17'd40, 32'hffff_ffff);
        repeat (42) send_tick();
        drain_frames();
    endtask

    // main sequence
    initial begin
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_bus.valid         <= 1'b0;
        in_bus.operation     <= OP_WRITE;
        in_bus.write_address <= '0;
        in_bus.left_sample   <= '0;
        in_bus.right_sample  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_loop();
        test_interp_extremes();
        test_single_frame();
        test_count_clip();
        test_random_traffic();
        test_output_hold();
        test_loop_wrap_sweep();

        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d write beats and %0d tick beats, %0d output frames checked",
                 writes_sent, ticks_sent, frames_checked);
        $display("idle and stall mixes, a long output hold, count clipping and a loop-end wrap");
        if (mismatches == 0) begin
            $display("looped_sample_resampler verification clean");
        end else begin
            $display("looped_sample_resampler verification failed");
        end
        $finish;
    end

endmodule
